// ===== rtl/core/crbd_pkg.sv =====
// ----------------------------------------------------------------------------
// crbd_pkg
// Shared types and constants of the diagonal-first CSR row builder.
// ----------------------------------------------------------------------------
package crbd_pkg;

  // Fixed field widths of the request payloads.
  localparam int unsigned ColW    = 16;
  localparam int unsigned ValW    = 64;
  localparam int unsigned Col1W   = 17;
  localparam int unsigned RowPtrW = 25;
  localparam int unsigned StatW   = 2;

  // One buffer entry holds the column above the value bits.
  localparam int unsigned EntryW  = ColW + ValW;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    STAT_OK           = 2'd0,
    STAT_MISSING_DIAG = 2'd1,
    STAT_OVERFLOW     = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_FILL,
    ST_DRAIN,
    ST_FLAG
  } state_e;

  // A buffer read issued by the controller, with its side information.
  typedef struct packed {
    logic               issue;
    logic               last;
    logic [RowPtrW-1:0] ptr;
  } rd_issue_t;

  // A single flagged result for a row that cannot be emitted.
  typedef struct packed {
    logic               push;
    status_e            status;
    logic [RowPtrW-1:0] ptr;
  } err_push_t;

  // Space reported by the output stage.
  typedef struct packed {
    logic rd_free;
    logic err_free;
  } out_stat_t;

endpackage

// ===== rtl/core/crbd_if.sv =====
// ----------------------------------------------------------------------------
// crbd_if
// Valid/ready channels carrying entry requests in and result requests out.
// ----------------------------------------------------------------------------
interface crbd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] column;
  logic [63:0] entry_value;
  logic        row_end;
  logic        matrix_start;

  modport source (output valid, column, entry_value, row_end, matrix_start, input ready);
  modport sink   (input valid, column, entry_value, row_end, matrix_start, output ready);
endinterface

interface crbd_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] column_one_based;
  logic [63:0] value_bits;
  logic [24:0] row_pointer;
  logic        last;
  logic [1:0]  status;

  modport source (output valid, column_one_based, value_bits, row_pointer, last, status,
                  input ready);
  modport sink   (input valid, column_one_based, value_bits, row_pointer, last, status,
                  output ready);
endinterface

// ===== rtl/core/crbd_row_mem.sv =====
// ----------------------------------------------------------------------------
// crbd_row_mem
// Row buffer: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crbd_row_mem
  import crbd_pkg::*;
#(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [EntryW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem_q [Depth];
  logic [EntryW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/crbd_out_stage.sv =====
// ----------------------------------------------------------------------------
// crbd_out_stage
// Holds buffer read data in flight and the registered result request.
// ----------------------------------------------------------------------------
module crbd_out_stage
  import crbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rd_issue_t         rd_i,
  input  err_push_t         err_i,
  input  logic [EntryW-1:0] rdata_i,
  output out_stat_t         stat_o,
  crbd_out_if.source        out_o
);

  logic               rd_pend_q, rd_pend_d;
  logic               rd_last_q;
  logic [RowPtrW-1:0] rd_ptr_q;
  logic               out_valid_q, out_valid_d;
  logic [Col1W-1:0]   col1_q;
  logic [ValW-1:0]    val_q;
  logic [RowPtrW-1:0] ptr_q;
  logic               last_q;
  status_e            status_q;
  logic               out_free;
  logic               load_rd;

  // The result register is free when empty or being taken.
  assign out_free = !out_valid_q || out_o.ready;
  assign load_rd  = rd_pend_q && out_free;

  assign stat_o.rd_free  = !rd_pend_q || load_rd;
  assign stat_o.err_free = !rd_pend_q && out_free;

  // Pending read data and result valid flags.
  always_comb begin
    rd_pend_d = rd_pend_q;
    if (rd_i.issue) begin
      rd_pend_d = 1'b1;
    end else if (load_rd) begin
      rd_pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load_rd || err_i.push) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Side information travelling with a read.
  always_ff @(posedge clk_i) begin
    if (rd_i.issue) begin
      rd_last_q <= rd_i.last;
      rd_ptr_q  <= rd_i.ptr;
    end
  end

  // Result payload, from buffer data or from a flagged row.
  always_ff @(posedge clk_i) begin
    if (load_rd) begin
      col1_q   <= Col1W'(rdata_i[EntryW-1:ValW]) + Col1W'(1);
      val_q    <= rdata_i[ValW-1:0];
      ptr_q    <= rd_last_q ? rd_ptr_q : '0;
      last_q   <= rd_last_q;
      status_q <= STAT_OK;
    end else if (err_i.push) begin
      col1_q   <= '0;
      val_q    <= '0;
      ptr_q    <= err_i.ptr;
      last_q   <= 1'b1;
      status_q <= err_i.status;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.column_one_based = col1_q;
  assign out_o.value_bits       = val_q;
  assign out_o.row_pointer      = ptr_q;
  assign out_o.last             = last_q;
  assign out_o.status           = StatW'(status_q);

endmodule

// ===== rtl/core/crbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// crbd_ctrl
// Row fill and drain sequencer: tracks the row, the diagonal and the totals,
// and issues buffer reads in diagonal-first order.
// ----------------------------------------------------------------------------
module crbd_ctrl
  import crbd_pkg::*;
#(
  parameter int unsigned MaxRowNz = 32,
  parameter int unsigned MaxDim   = 65536,
  parameter int unsigned MaxNnz   = 16777216,
  parameter int unsigned AddrW    = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ColW-1:0]  column_i,
  input  logic             row_end_i,
  input  logic             matrix_start_i,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  output rd_issue_t        rd_o,
  output err_push_t        err_o,
  input  out_stat_t        stat_i
);

  localparam int unsigned CntW = $clog2(MaxRowNz + 1);
  localparam int unsigned RowW = $clog2(MaxDim);
  localparam int unsigned TotW = $clog2(MaxNnz + 1);
  localparam int unsigned SumW = TotW + 7;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [AddrW-1:0]    diag_pos_q, diag_pos_d;
  logic                diag_found_q, diag_found_d;
  logic                ovf_q, ovf_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [TotW-1:0]     total_q, total_d;
  logic [CntW-1:0]     drn_idx_q, drn_idx_d;
  logic [CntW-1:0]     drn_len_q, drn_len_d;
  logic [AddrW-1:0]    drn_pos_q, drn_pos_d;
  logic [RowPtrW-1:0]  drn_ptr_q, drn_ptr_d;
  status_e             err_stat_q, err_stat_d;

  logic                accept;
  logic [CntW-1:0]     eff_count;
  logic [AddrW-1:0]    eff_pos;
  logic                eff_found;
  logic                eff_ovf;
  logic [RowW-1:0]     eff_row;
  logic [TotW-1:0]     eff_total;
  logic                room;
  logic                hit;
  logic [CntW-1:0]     new_count;
  logic [AddrW-1:0]    new_pos;
  logic                new_found;
  logic                new_ovf;
  logic [SumW-1:0]     sum;
  logic [TotW-1:0]     new_total;
  logic [RowW-1:0]     next_row;
  logic                drn_last;

  assign in_ready_o = (state_q == ST_FILL);
  assign accept     = in_valid_i && in_ready_o;

  // Row state as seen by this entry; a matrix start clears it first.
  always_comb begin
    eff_count = matrix_start_i ? '0 : count_q;
    eff_pos   = matrix_start_i ? '0 : diag_pos_q;
    eff_found = matrix_start_i ? 1'b0 : diag_found_q;
    eff_ovf   = matrix_start_i ? 1'b0 : ovf_q;
    eff_row   = matrix_start_i ? '0 : row_q;
    eff_total = matrix_start_i ? '0 : total_q;
  end

  // Buffer the entry if there is room and note a diagonal hit.
  always_comb begin
    room      = (eff_count < CntW'(MaxRowNz));
    hit       = room && (column_i == ColW'(eff_row));
    new_count = eff_count + CntW'(room);
    new_pos   = hit ? eff_count[AddrW-1:0] : eff_pos;
    new_found = eff_found || hit;
    new_ovf   = eff_ovf || !room;
    sum       = SumW'(eff_total) + SumW'(new_count);
    new_total = (sum > SumW'(MaxNnz)) ? TotW'(MaxNnz) : sum[TotW-1:0];
    next_row  = (eff_row == RowW'(MaxDim - 1)) ? '0 : eff_row + RowW'(1);
  end

  assign mem_we_o    = accept && room;
  assign mem_waddr_o = eff_count[AddrW-1:0];

  // Diagonal-first read order: slot zero and the diagonal slot trade places.
  assign drn_last = ((drn_idx_q + CntW'(1)) == drn_len_q);

  always_comb begin
    if (drn_idx_q == '0) begin
      mem_raddr_o = drn_pos_q;
    end else if (drn_idx_q[AddrW-1:0] == drn_pos_q) begin
      mem_raddr_o = '0;
    end else begin
      mem_raddr_o = drn_idx_q[AddrW-1:0];
    end
  end

  // Next state and outputs.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    diag_pos_d   = diag_pos_q;
    diag_found_d = diag_found_q;
    ovf_d        = ovf_q;
    row_d        = row_q;
    total_d      = total_q;
    drn_idx_d    = drn_idx_q;
    drn_len_d    = drn_len_q;
    drn_pos_d    = drn_pos_q;
    drn_ptr_d    = drn_ptr_q;
    err_stat_d   = err_stat_q;
    mem_re_o     = 1'b0;
    rd_o.issue   = 1'b0;
    rd_o.last    = drn_last;
    rd_o.ptr     = drn_ptr_q;
    err_o.push   = 1'b0;
    err_o.status = err_stat_q;
    err_o.ptr    = drn_ptr_q;

    unique case (state_q)
      ST_FILL: begin
        if (accept) begin
          total_d = eff_total;
          row_d   = eff_row;
          if (!row_end_i) begin
            count_d      = new_count;
            diag_pos_d   = new_pos;
            diag_found_d = new_found;
            ovf_d        = new_ovf;
          end else begin
            count_d      = '0;
            diag_pos_d   = '0;
            diag_found_d = 1'b0;
            ovf_d        = 1'b0;
            row_d        = next_row;
            drn_idx_d    = '0;
            drn_len_d    = new_count;
            drn_pos_d    = new_pos;
            if (new_ovf || !new_found) begin
              // Flagged row: one result, the total stays as it is.
              err_stat_d = new_ovf ? STAT_OVERFLOW : STAT_MISSING_DIAG;
              drn_ptr_d  = RowPtrW'(eff_total) + RowPtrW'(1);
              state_d    = ST_FLAG;
            end else begin
              total_d   = new_total;
              drn_ptr_d = RowPtrW'(new_total) + RowPtrW'(1);
              state_d   = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (stat_i.rd_free) begin
          mem_re_o   = 1'b1;
          rd_o.issue = 1'b1;
          drn_idx_d  = drn_idx_q + CntW'(1);
          if (drn_last) begin
            state_d = ST_FILL;
          end
        end
      end
      ST_FLAG: begin
        if (stat_i.err_free) begin
          err_o.push = 1'b1;
          state_d    = ST_FILL;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      count_q      <= '0;
      diag_pos_q   <= '0;
      diag_found_q <= 1'b0;
      ovf_q        <= 1'b0;
      row_q        <= '0;
      total_q      <= '0;
      drn_idx_q    <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      diag_pos_q   <= diag_pos_d;
      diag_found_q <= diag_found_d;
      ovf_q        <= ovf_d;
      row_q        <= row_d;
      total_q      <= total_d;
      drn_idx_q    <= drn_idx_d;
    end
  end

  // Drain descriptor of the row being emitted.
  always_ff @(posedge clk_i) begin
    drn_len_q  <= drn_len_d;
    drn_pos_q  <= drn_pos_d;
    drn_ptr_q  <= drn_ptr_d;
    err_stat_q <= err_stat_d;
  end

`ifndef SYNTHESIS
  // The fill count never passes the buffer depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxRowNz))
    else $error("row fill count beyond buffer depth");

  // While draining, the read index stays inside the row.
  a_drain_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (drn_idx_q < drn_len_q))
    else $error("drain index beyond row length");

  // The diagonal slot of a draining row lies inside the row.
  a_drain_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (CntW'(drn_pos_q) < drn_len_q))
    else $error("diagonal slot beyond row length");

  // Issuing the last read of a row returns to filling.
  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_o.issue && rd_o.last) |=> (state_q == ST_FILL))
    else $error("drain did not finish after last read");
`endif

endmodule

// ===== rtl/core/csr_row_builder_diagonal_first.sv =====
// The block takes one nonzero entry request per cycle while it fills a row. When
// an entry with row_end is taken, it stops taking requests and reads the row
// buffer back, one entry per cycle while the result stage has room for it,
// through the buffer's single read port, with the diagonal entry first. A row
// that overflows the buffer or has no diagonal entry gives a single flagged
// result instead. The last drain read overlaps the filling of the next row, and
// a result register lets the next request be taken while a result waits. The
// buffer needs no clearing pass after reset.
// ----------------------------------------------------------------------------
// csr_row_builder_diagonal_first
// Builds CSR rows from row-major nonzero entries, diagonal entry first.
// ----------------------------------------------------------------------------
module csr_row_builder_diagonal_first
  import crbd_pkg::*;
#(
  parameter int unsigned MAX_ROW_NZ = 32,
  parameter int unsigned MAX_DIM    = 65536,
  parameter int unsigned MAX_NNZ    = 16777216
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crbd_in_if.sink    in_i,
  crbd_out_if.source out_o
);

  localparam int unsigned AddrW = (MAX_ROW_NZ > 1) ? $clog2(MAX_ROW_NZ) : 1;

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [EntryW-1:0] mem_wdata;
  logic [EntryW-1:0] mem_rdata;
  rd_issue_t         rd_issue;
  err_push_t         err_push;
  out_stat_t         out_stat;

  // Buffer entries carry the column above the value bits.
  assign mem_wdata = {in_i.column, in_i.entry_value};

  // Fill and drain sequencer.
  crbd_ctrl #(
    .MaxRowNz (MAX_ROW_NZ),
    .MaxDim   (MAX_DIM),
    .MaxNnz   (MAX_NNZ),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .column_i       (in_i.column),
    .row_end_i      (in_i.row_end),
    .matrix_start_i (in_i.matrix_start),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .rd_o           (rd_issue),
    .err_o          (err_push),
    .stat_i         (out_stat)
  );

  // Row buffer.
  crbd_row_mem #(
    .Depth (MAX_ROW_NZ),
    .AddrW (AddrW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result register.
  crbd_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (rd_issue),
    .err_i   (err_push),
    .rdata_i (mem_rdata),
    .stat_o  (out_stat),
    .out_o   (out_o)
  );

endmodule
